// ===== src/jacobi_eigen_rotation_engine_core_assert.svh =====
// Assertion macros used by the engine core.
`ifndef JACOBI_EIGEN_ROTATION_ENGINE_CORE_ASSERT_SVH
`define JACOBI_EIGEN_ROTATION_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define JERE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define JERE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/jere_pkg.sv =====
package jere_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_ITER  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_ROT   = 2'd1;
	localparam logic [1:0] STAT_CONV  = 2'd2;
	localparam logic [1:0] STAT_LIMIT = 2'd3;

	localparam logic [1:0] CFG_TOL   = 2'd0;
	localparam logic [1:0] CFG_LIMIT = 2'd1;
	localparam logic [1:0] CFG_SIZE  = 2'd2;

	localparam logic [6:0] ITU_SQRT_STEPS = 7'd32;
	localparam logic [6:0] ITU_DIV_STEPS  = 7'd64;

	typedef enum logic [5:0] {
		S_IDLE, S_WR, S_RD_A, S_RD_D, S_IT_CHK,
		S_SC_RD, S_SC_CMP, S_SC_END, S_PV_W, S_PV_U, S_PV_G, S_XY_SH,
		S_MUL_XX, S_MUL_YY, S_SQ1_GO, S_SQ1_W, S_DV1_GO, S_DV1_W,
		S_MUL_TT, S_SQ2_GO, S_SQ2_W, S_DV2_GO, S_DV2_W,
		S_MUL_CT, S_S_SET, S_MUL_SS, S_MUL_CS, S_K_INIT,
		S_K_NEXT, S_K_RA, S_K_RB, S_K_M1, S_K_M2, S_K_M3, S_K_M4,
		S_D_M1, S_D_M2, S_D_M3, S_D_M4, S_D_M5, S_D_M6, S_D_ZERO, S_FIN
	} fsm_state_t;

	typedef struct packed {
		logic        start;
		logic        is_sqrt;
		logic [63:0] opa;
		logic [32:0] opb;
	} itu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} itu_rsp_t;

endpackage

// ===== src/jere_in_if.sv =====
interface jere_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [2:0]         row;
	logic [2:0]         col;
	logic signed [31:0] value;

	modport source(output valid, opcode, row, col, value, input ready);
	modport sink(input valid, opcode, row, col, value, output ready);
endinterface

// ===== src/jere_out_if.sv =====
interface jere_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] read_value;
	logic [2:0]         pair_low;
	logic [2:0]         pair_high;
	logic signed [31:0] cosine;
	logic signed [31:0] sine;

	modport source(output valid, status, read_value, pair_low, pair_high, cosine, sine,
		input ready);
	modport sink(input valid, status, read_value, pair_low, pair_high, cosine, sine,
		output ready);
endinterface

// ===== src/jere_itu.sv =====
// Shared iterative unit: restoring divide (64/33, one bit a cycle) or
// integer square root (64-bit, two bits a cycle).
module jere_itu (
	input  logic               clk,
	input  logic               arst_n,
	input  jere_pkg::itu_req_t req,
	output jere_pkg::itu_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic        sqrt_q;
	logic [6:0]  cnt_q;
	logic [63:0] sh_q;
	logic [63:0] res_q;
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [35:0] cur;
	logic [35:0] trial;
	logic [36:0] diff;
	logic        ge;

	always_comb begin
		cur   = sqrt_q ? {rem_q, sh_q[63:62]} : {1'b0, rem_q, sh_q[63]};
		trial = sqrt_q ? {2'b00, res_q[31:0], 2'b01} : {3'b000, den_q};
		diff  = {1'b0, cur} - {1'b0, trial};
		ge    = !diff[36];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sqrt_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			sqrt_q <= req.is_sqrt;
			cnt_q  <= req.is_sqrt ? jere_pkg::ITU_SQRT_STEPS : jere_pkg::ITU_DIV_STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q  <= req.opa;
			den_q <= req.opb;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[33:0] : cur[33:0];
			res_q <= {res_q[62:0], ge};
			sh_q  <= sqrt_q ? {sh_q[61:0], 2'b00} : {sh_q[62:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

// ===== src/jacobi_eigen_rotation_engine_core.sv =====
// Channel | Dir | Payload                                          | Transfer
// req     | in  | opcode, row, col, value                          | valid & ready
// rsp     | out | status, read_value, pair_low/high, cosine, sine  | valid & ready
// cfg     | in  | cfg_index, cfg_data                              | cfg_we
//
// An iteration scans entries, takes roots and quotients in the shared unit and
// updates columns; all multiplies go through one shared 32x32 multiplier.
// req.ready is high only while idle; a finished result waits in the output
// register, so the next item may be taken before rsp accepts the last one.
// arst_n clears control state and config registers; the matrix store and data registers are not cleared.
`include "jacobi_eigen_rotation_engine_core_assert.svh"

module jacobi_eigen_rotation_engine_core #(
	parameter int MAX_N     = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	jere_in_if.sink     req,
	jere_out_if.source  rsp
);

	localparam int SD   = MAX_N * (MAX_N + 1) / 2;
	localparam int AW   = $clog2(SD);
	localparam int IW   = $clog2(MAX_N);
	localparam int NW   = $clog2(MAX_N + 1);
	localparam int ACCW = 40;
	localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);
	localparam logic [63:0] ONE2 = 64'(1) << (2 * FRAC_BITS);

	function automatic logic [AW-1:0] slot(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [IW-1:0] lo;
		logic [IW-1:0] hi;
		int            t;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		t  = (int'(lo) * (2 * MAX_N - int'(lo) - 1)) >>> 1;
		return AW'(t + int'(hi));
	endfunction

	function automatic logic [31:0] umag32(input logic [31:0] a);
		return a[31] ? (~a + 32'd1) : a;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [ACCW-1:0] v);
		if (v > $signed(ACCW'(32'h7FFF_FFFF)))
			return 32'h7FFF_FFFF;
		else if (v < $signed({{(ACCW-31){1'b1}}, 31'b0}))
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

	jere_pkg::fsm_state_t state_q, state_d;

	logic [30:0] tol_q;
	logic [15:0] lim_q;
	logic [3:0]  size_q;
	logic [15:0] iter_q;

	logic [1:0]  op_q;
	logic [2:0]  row_q, col_q;
	logic [31:0] value_q;
	logic [1:0]  res_status_q;
	logic [31:0] rdv_q;

	logic [31:0] store_q [SD];
	logic [31:0] rdata_q;
	logic        mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [31:0] mem_wd;

	logic [NW-1:0] n_q, i_q, j_q, k_q, n_d;
	logic [IW-1:0] p_q, q_q;
	logic [31:0] best_q;

	logic signed [31:0] app_q, aqq_q, g_q, a_q, b_q;
	logic [32:0] x_q, y_q;
	logic        sneg_q;
	logic [63:0] sum_q, prod_q;
	logic        mneg_q, mneg_d;
	logic [31:0] mul_a, mul_b;
	logic [32:0] den_q;
	logic [31:0] tmag_q, sq_q, cm_q, sm_q, cc_q, ss_q, cs_q;
	logic signed [ACCW-1:0] acc_q, cv_q, fm;
	logic [63:0] rsum;

	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [31:0] out_rd_q, out_c_q, out_s_q;
	logic [2:0]  out_lo_q, out_hi_q;

	jere_pkg::itu_req_t itu_req;
	jere_pkg::itu_rsp_t itu_rsp;

	logic accept, in_range, out_free, sc_more_i, sc_more_j, k_hit, k_end;
	logic signed [32:0] hdiff;
	logic [31:0] scan_mag;

	jere_itu u_itu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (itu_req),
		.rsp    (itu_rsp)
	);

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == jere_pkg::S_IDLE);
	assign in_range  = (int'(row_q) < MAX_N) && (int'(col_q) < MAX_N);
	assign out_free  = !out_valid_q || rsp.ready;
	assign sc_more_i = ({1'b0, i_q} + (NW+1)'(1)) < {1'b0, n_q};
	assign sc_more_j = ({1'b0, j_q} + (NW+1)'(2)) < {1'b0, n_q};
	assign k_hit     = (k_q == NW'(p_q)) || (k_q == NW'(q_q));
	assign k_end     = (k_q == n_q);
	assign hdiff     = {aqq_q[31], aqq_q} - {app_q[31], app_q};
	assign scan_mag  = umag32(rdata_q);
	assign rsum      = prod_q + HALF;

	always_comb begin
		fm = $signed(ACCW'(rsum >> FRAC_BITS));
		if (mneg_q)
			fm = -fm;
	end

	always_comb begin
		if (size_q < 4'd2)
			n_d = NW'(2);
		else if (int'(size_q) > MAX_N)
			n_d = NW'(MAX_N);
		else
			n_d = NW'(size_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			store_q[mem_wa] <= mem_wd;
		rdata_q <= store_q[mem_ra];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			jere_pkg::S_IDLE: begin
				if (accept) begin
					case (req.opcode)
						jere_pkg::OP_WRITE: state_d = jere_pkg::S_WR;
						jere_pkg::OP_READ:  state_d = jere_pkg::S_RD_A;
						jere_pkg::OP_ITER:  state_d = jere_pkg::S_IT_CHK;
						default:            state_d = jere_pkg::S_FIN;
					endcase
				end
			end
			jere_pkg::S_WR:     state_d = jere_pkg::S_FIN;
			jere_pkg::S_RD_A:   state_d = jere_pkg::S_RD_D;
			jere_pkg::S_RD_D:   state_d = jere_pkg::S_FIN;
			jere_pkg::S_IT_CHK: state_d = (iter_q >= lim_q) ? jere_pkg::S_FIN : jere_pkg::S_SC_RD;
			jere_pkg::S_SC_RD:  state_d = jere_pkg::S_SC_CMP;
			jere_pkg::S_SC_CMP: state_d = (sc_more_i || sc_more_j) ? jere_pkg::S_SC_RD
				: jere_pkg::S_SC_END;
			jere_pkg::S_SC_END: state_d = (best_q == 32'd0 || best_q < {1'b0, tol_q})
				? jere_pkg::S_FIN : jere_pkg::S_PV_W;
			jere_pkg::S_PV_W:   state_d = jere_pkg::S_PV_U;
			jere_pkg::S_PV_U:   state_d = jere_pkg::S_PV_G;
			jere_pkg::S_PV_G:   state_d = jere_pkg::S_XY_SH;
			jere_pkg::S_XY_SH: begin
				if (x_q[32:31] == 2'b00 && y_q[32:31] == 2'b00)
					state_d = jere_pkg::S_MUL_XX;
			end
			jere_pkg::S_MUL_XX: state_d = jere_pkg::S_MUL_YY;
			jere_pkg::S_MUL_YY: state_d = jere_pkg::S_SQ1_GO;
			jere_pkg::S_SQ1_GO: state_d = jere_pkg::S_SQ1_W;
			jere_pkg::S_SQ1_W:  if (itu_rsp.done) state_d = jere_pkg::S_DV1_GO;
			jere_pkg::S_DV1_GO: state_d = jere_pkg::S_DV1_W;
			jere_pkg::S_DV1_W:  if (itu_rsp.done) state_d = jere_pkg::S_MUL_TT;
			jere_pkg::S_MUL_TT: state_d = jere_pkg::S_SQ2_GO;
			jere_pkg::S_SQ2_GO: state_d = jere_pkg::S_SQ2_W;
			jere_pkg::S_SQ2_W:  if (itu_rsp.done) state_d = jere_pkg::S_DV2_GO;
			jere_pkg::S_DV2_GO: state_d = jere_pkg::S_DV2_W;
			jere_pkg::S_DV2_W:  if (itu_rsp.done) state_d = jere_pkg::S_MUL_CT;
			jere_pkg::S_MUL_CT: state_d = jere_pkg::S_S_SET;
			jere_pkg::S_S_SET:  state_d = jere_pkg::S_MUL_SS;
			jere_pkg::S_MUL_SS: state_d = jere_pkg::S_MUL_CS;
			jere_pkg::S_MUL_CS: state_d = jere_pkg::S_K_INIT;
			jere_pkg::S_K_INIT: state_d = jere_pkg::S_K_NEXT;
			jere_pkg::S_K_NEXT: begin
				if (k_end)
					state_d = jere_pkg::S_D_M1;
				else if (!k_hit)
					state_d = jere_pkg::S_K_RA;
			end
			jere_pkg::S_K_RA:   state_d = jere_pkg::S_K_RB;
			jere_pkg::S_K_RB:   state_d = jere_pkg::S_K_M1;
			jere_pkg::S_K_M1:   state_d = jere_pkg::S_K_M2;
			jere_pkg::S_K_M2:   state_d = jere_pkg::S_K_M3;
			jere_pkg::S_K_M3:   state_d = jere_pkg::S_K_M4;
			jere_pkg::S_K_M4:   state_d = jere_pkg::S_K_NEXT;
			jere_pkg::S_D_M1:   state_d = jere_pkg::S_D_M2;
			jere_pkg::S_D_M2:   state_d = jere_pkg::S_D_M3;
			jere_pkg::S_D_M3:   state_d = jere_pkg::S_D_M4;
			jere_pkg::S_D_M4:   state_d = jere_pkg::S_D_M5;
			jere_pkg::S_D_M5:   state_d = jere_pkg::S_D_M6;
			jere_pkg::S_D_M6:   state_d = jere_pkg::S_D_ZERO;
			jere_pkg::S_D_ZERO: state_d = jere_pkg::S_FIN;
			jere_pkg::S_FIN:    if (out_free) state_d = jere_pkg::S_IDLE;
			default:            state_d = jere_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = '0;
		mem_wd  = '0;
		mem_ra  = '0;
		mul_a   = '0;
		mul_b   = '0;
		mneg_d  = 1'b0;
		itu_req = '0;
		case (state_q)
			jere_pkg::S_WR: begin
				mem_we = in_range;
				mem_wa = slot(IW'(row_q), IW'(col_q));
				mem_wd = value_q;
			end
			jere_pkg::S_RD_A:   mem_ra = slot(IW'(row_q), IW'(col_q));
			jere_pkg::S_SC_RD:  mem_ra = slot(IW'(i_q), IW'(j_q));
			jere_pkg::S_SC_END: mem_ra = slot(q_q, q_q);
			jere_pkg::S_PV_W:   mem_ra = slot(p_q, p_q);
			jere_pkg::S_PV_U:   mem_ra = slot(q_q, p_q);
			jere_pkg::S_MUL_XX: begin
				mul_a = x_q[31:0];
				mul_b = x_q[31:0];
			end
			jere_pkg::S_MUL_YY: begin
				mul_a = y_q[31:0];
				mul_b = y_q[31:0];
			end
			jere_pkg::S_SQ1_GO: begin
				itu_req.start   = 1'b1;
				itu_req.is_sqrt = 1'b1;
				itu_req.opa     = sum_q + prod_q;
			end
			jere_pkg::S_DV1_GO: begin
				itu_req.start = 1'b1;
				itu_req.opa   = (64'(y_q) << FRAC_BITS) + 64'(den_q >> 1);
				itu_req.opb   = den_q;
			end
			jere_pkg::S_MUL_TT: begin
				mul_a = tmag_q;
				mul_b = tmag_q;
			end
			jere_pkg::S_SQ2_GO: begin
				itu_req.start   = 1'b1;
				itu_req.is_sqrt = 1'b1;
				itu_req.opa     = prod_q + ONE2;
			end
			jere_pkg::S_DV2_GO: begin
				itu_req.start = 1'b1;
				itu_req.opa   = ONE2 + 64'(sq_q >> 1);
				itu_req.opb   = {1'b0, sq_q};
			end
			jere_pkg::S_MUL_CT: begin
				mul_a = cm_q;
				mul_b = tmag_q;
			end
			jere_pkg::S_S_SET: begin
				mul_a = cm_q;
				mul_b = cm_q;
			end
			jere_pkg::S_MUL_SS: begin
				mul_a = sm_q;
				mul_b = sm_q;
			end
			jere_pkg::S_MUL_CS: begin
				mul_a = cm_q;
				mul_b = sm_q;
			end
			jere_pkg::S_K_NEXT: mem_ra = slot(p_q, IW'(k_q));
			jere_pkg::S_K_RA:   mem_ra = slot(q_q, IW'(k_q));
			jere_pkg::S_K_RB: begin
				mul_a  = cm_q;
				mul_b  = umag32(a_q);
				mneg_d = a_q[31];
			end
			jere_pkg::S_K_M1: begin
				mul_a  = sm_q;
				mul_b  = umag32(b_q);
				mneg_d = sneg_q ^ b_q[31];
			end
			jere_pkg::S_K_M2: begin
				mem_we = 1'b1;
				mem_wa = slot(p_q, IW'(k_q));
				mem_wd = sat32(acc_q - fm);
				mul_a  = sm_q;
				mul_b  = umag32(a_q);
				mneg_d = sneg_q ^ a_q[31];
			end
			jere_pkg::S_K_M3: begin
				mul_a  = cm_q;
				mul_b  = umag32(b_q);
				mneg_d = b_q[31];
			end
			jere_pkg::S_K_M4: begin
				mem_we = 1'b1;
				mem_wa = slot(q_q, IW'(k_q));
				mem_wd = sat32(acc_q + fm);
			end
			jere_pkg::S_D_M1: begin
				mul_a  = cc_q;
				mul_b  = umag32(app_q);
				mneg_d = app_q[31];
			end
			jere_pkg::S_D_M2: begin
				mul_a  = cs_q;
				mul_b  = umag32(g_q);
				mneg_d = sneg_q ^ g_q[31];
			end
			jere_pkg::S_D_M3: begin
				mul_a  = ss_q;
				mul_b  = umag32(aqq_q);
				mneg_d = aqq_q[31];
			end
			jere_pkg::S_D_M4: begin
				mem_we = 1'b1;
				mem_wa = slot(p_q, p_q);
				mem_wd = sat32(acc_q + fm);
				mul_a  = cc_q;
				mul_b  = umag32(aqq_q);
				mneg_d = aqq_q[31];
			end
			jere_pkg::S_D_M5: begin
				mul_a  = ss_q;
				mul_b  = umag32(app_q);
				mneg_d = app_q[31];
			end
			jere_pkg::S_D_M6: begin
				mem_we = 1'b1;
				mem_wa = slot(q_q, q_q);
				mem_wd = sat32(acc_q + fm);
			end
			jere_pkg::S_D_ZERO: begin
				mem_we = 1'b1;
				mem_wa = slot(q_q, p_q);
				mem_wd = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jere_pkg::S_IDLE;
			tol_q       <= 31'd1;
			lim_q       <= 16'd1024;
			size_q      <= 4'd8;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					jere_pkg::CFG_TOL:   tol_q  <= cfg_data;
					jere_pkg::CFG_LIMIT: lim_q  <= cfg_data[15:0];
					jere_pkg::CFG_SIZE:  size_q <= cfg_data[3:0];
					default: begin
					end
				endcase
			end
			if (state_q == jere_pkg::S_WR && in_range)
				iter_q <= '0;
			else if (state_q == jere_pkg::S_D_ZERO && iter_q != 16'hFFFF)
				iter_q <= iter_q + 16'd1;
			if (state_q == jere_pkg::S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		mneg_q <= mneg_d;
		case (state_q)
			jere_pkg::S_IDLE: begin
				op_q         <= req.opcode;
				row_q        <= req.row;
				col_q        <= req.col;
				value_q      <= req.value;
				res_status_q <= jere_pkg::STAT_DONE;
				rdv_q        <= '0;
			end
			jere_pkg::S_RD_D: rdv_q <= in_range ? rdata_q : 32'd0;
			jere_pkg::S_IT_CHK: begin
				if (iter_q >= lim_q)
					res_status_q <= jere_pkg::STAT_LIMIT;
				n_q    <= n_d;
				j_q    <= '0;
				i_q    <= NW'(1);
				best_q <= '0;
				p_q    <= '0;
				q_q    <= '0;
			end
			jere_pkg::S_SC_CMP: begin
				if (scan_mag > best_q) begin
					best_q <= scan_mag;
					p_q    <= IW'(j_q);
					q_q    <= IW'(i_q);
				end
				if (sc_more_i) begin
					i_q <= i_q + NW'(1);
				end else begin
					j_q <= j_q + NW'(1);
					i_q <= j_q + NW'(2);
				end
			end
			jere_pkg::S_SC_END: begin
				if (best_q == 32'd0 || best_q < {1'b0, tol_q})
					res_status_q <= jere_pkg::STAT_CONV;
			end
			jere_pkg::S_PV_W: aqq_q <= rdata_q;
			jere_pkg::S_PV_U: app_q <= rdata_q;
			jere_pkg::S_PV_G: begin
				g_q    <= rdata_q;
				x_q    <= hdiff[32] ? (~hdiff + 33'd1) : hdiff;
				y_q    <= {scan_mag, 1'b0};
				sneg_q <= !(((!hdiff[32] && hdiff != 33'd0) && (!rdata_q[31] && rdata_q != 32'd0))
					|| (hdiff[32] && rdata_q[31]));
			end
			jere_pkg::S_XY_SH: begin
				if (x_q[32:31] != 2'b00 || y_q[32:31] != 2'b00) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
				end
			end
			jere_pkg::S_MUL_YY: sum_q <= prod_q;
			jere_pkg::S_SQ1_W:  den_q <= {1'b0, x_q[31:0]} + {1'b0, itu_rsp.res[31:0]};
			jere_pkg::S_DV1_W:  tmag_q <= itu_rsp.res[31:0];
			jere_pkg::S_SQ2_W:  sq_q <= itu_rsp.res[31:0];
			jere_pkg::S_DV2_W:  cm_q <= itu_rsp.res[31:0];
			jere_pkg::S_S_SET:  sm_q <= fm[31:0];
			jere_pkg::S_MUL_SS: cc_q <= fm[31:0];
			jere_pkg::S_MUL_CS: ss_q <= fm[31:0];
			jere_pkg::S_K_INIT: begin
				cs_q <= fm[31:0];
				k_q  <= '0;
			end
			jere_pkg::S_K_NEXT: if (!k_end && k_hit) k_q <= k_q + NW'(1);
			jere_pkg::S_K_RA:   a_q <= rdata_q;
			jere_pkg::S_K_RB:   b_q <= rdata_q;
			jere_pkg::S_K_M1:   acc_q <= fm;
			jere_pkg::S_K_M3:   acc_q <= fm;
			jere_pkg::S_K_M4:   k_q <= k_q + NW'(1);
			jere_pkg::S_D_M2:   acc_q <= fm;
			jere_pkg::S_D_M3: begin
				cv_q  <= fm;
				acc_q <= acc_q - (fm <<< 1);
			end
			jere_pkg::S_D_M5:   acc_q <= fm + (cv_q <<< 1);
			jere_pkg::S_D_ZERO: res_status_q <= jere_pkg::STAT_ROT;
			jere_pkg::S_FIN: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_rd_q     <= rdv_q;
					if (res_status_q == jere_pkg::STAT_ROT) begin
						out_lo_q <= 3'(p_q);
						out_hi_q <= 3'(q_q);
						out_c_q  <= cm_q;
						out_s_q  <= sneg_q ? (~sm_q + 32'd1) : sm_q;
					end else begin
						out_lo_q <= '0;
						out_hi_q <= '0;
						out_c_q  <= '0;
						out_s_q  <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_value = out_rd_q;
	assign rsp.pair_low   = out_lo_q;
	assign rsp.pair_high  = out_hi_q;
	assign rsp.cosine     = out_c_q;
	assign rsp.sine       = out_s_q;

	`JERE_ASSERT_NOW(a_itu_done_in_wait, itu_rsp.done,
		(state_q == jere_pkg::S_SQ1_W) || (state_q == jere_pkg::S_DV1_W)
			|| (state_q == jere_pkg::S_SQ2_W) || (state_q == jere_pkg::S_DV2_W),
		"shared unit finished outside a wait state")
	`JERE_ASSERT_NOW(a_scan_index, state_q == jere_pkg::S_SC_RD,
		(i_q > j_q) && (i_q < n_q), "scan index outside lower triangle")
	`JERE_ASSERT_NOW(a_pivot_order, state_q == jere_pkg::S_D_ZERO,
		p_q < q_q, "pivot pair out of order")
	`JERE_ASSERT_NXT(a_accept_leaves_idle, req.valid && req.ready,
		state_q != jere_pkg::S_IDLE, "transfer accepted but engine stayed idle")

endmodule

// ===== sim/jere_rotation_checker.sv =====
module jere_rotation_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	jere_in_if          req,
	jere_out_if         rsp,
	output int          fail_count,
	output int          pending
);

	localparam int                 DIM  = 8;
	localparam int                 FB   = 16;
	localparam longint unsigned    ONE2 = 64'd1 << (2 * FB);
	localparam longint unsigned    HALF = 64'd1 << (FB - 1);
	localparam longint unsigned    LIM31 = 64'd1 << 31;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [2:0]         pair_low;
		logic [2:0]         pair_high;
		logic signed [31:0] cosine;
		logic signed [31:0] sine;
	} rot_result_t;

	logic signed [31:0] tri_mat [DIM * (DIM + 1) / 2];
	logic [15:0]        rot_count;
	logic [30:0]        tol_q;
	logic [15:0]        rot_limit;
	logic [3:0]         dim_reg;
	rot_result_t        result_q [$];

	function automatic int slot(int r, int k);
		int lo, hi;
		lo = (r < k) ? r : k;
		hi = (r < k) ? k : r;
		return lo * (2 * DIM - lo - 1) / 2 + hi;
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned umag(longint a);
		return (a < 0) ? longint'(-a) : a;
	endfunction

	function automatic longint qmul(longint a, longint b);
		longint unsigned m;
		m = (umag(a) * umag(b) + HALF) >> FB;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint el(int r, int k);
		return longint'(tri_mat[slot(r, k)]);
	endfunction

	task automatic put(int r, int k, longint v);
		tri_mat[slot(r, k)] = 32'(sat32(v));
	endtask

	task automatic jacobi_rotate(inout rot_result_t e);
		int n, p, q;
		longint unsigned best, m, x, y, rt, den, tm, sq;
		longint h, g, cv, sv, a, b, u, w, cc, ss, cs;
		bit tpos;
		n = (dim_reg < 2) ? 2 : ((dim_reg > DIM) ? DIM : int'(dim_reg));
		best = 0;
		p = 0;
		q = 0;
		for (int j = 0; j < n; j++)
			for (int i = j + 1; i < n; i++) begin
				m = umag(el(i, j));
				if (m > best) begin
					best = m;
					q = i;
					p = j;
				end
			end
		if (best == 0 || best < tol_q) begin
			e.status = jere_pkg::STAT_CONV;
			return;
		end
		h = el(q, q) - el(p, p);
		g = el(q, p);
		x = umag(h);
		y = 2 * umag(g);
		while (x >= LIM31 || y >= LIM31) begin
			x >>= 1;
			y >>= 1;
		end
		rt = int_sqrt(x * x + y * y);
		den = x + rt;
		tm = ((y << FB) + den / 2) / den;
		tpos = (h > 0 && g > 0) || (h < 0 && g < 0);
		sq = int_sqrt(tm * tm + ONE2);
		cv = longint'((ONE2 + sq / 2) / sq);
		sv = longint'((longint'(cv) * tm + HALF) >> FB);
		if (!tpos) sv = -sv;
		for (int k = 0; k < n; k++) begin
			if (k == p || k == q) continue;
			a = el(p, k);
			b = el(q, k);
			put(p, k, qmul(cv, a) - qmul(sv, b));
			put(q, k, qmul(sv, a) + qmul(cv, b));
		end
		u = el(p, p);
		w = el(q, q);
		cc = qmul(cv, cv);
		ss = qmul(sv, sv);
		cs = qmul(cv, sv);
		put(p, p, qmul(cc, u) - 2 * qmul(cs, g) + qmul(ss, w));
		put(q, q, qmul(cc, w) + 2 * qmul(cs, g) + qmul(ss, u));
		put(q, p, 0);
		if (rot_count != 16'hFFFF) rot_count++;
		e.status    = jere_pkg::STAT_ROT;
		e.pair_low  = 3'(p);
		e.pair_high = 3'(q);
		e.cosine    = 32'(sat32(cv));
		e.sine      = 32'(sat32(sv));
	endtask

	task automatic predict(logic [1:0] op, logic [2:0] r, logic [2:0] c,
		logic signed [31:0] v);
		rot_result_t e;
		e = '0;
		e.status = jere_pkg::STAT_DONE;
		case (op)
			jere_pkg::OP_WRITE: begin
				tri_mat[slot(r, c)] = v;
				rot_count = 0;
			end
			jere_pkg::OP_READ: e.read_value = tri_mat[slot(r, c)];
			jere_pkg::OP_ITER: begin
				if (rot_count >= rot_limit) e.status = jere_pkg::STAT_LIMIT;
				else jacobi_rotate(e);
			end
			default: ;
		endcase
		result_q.push_back(e);
	endtask

	task automatic compare(rot_result_t got);
		rot_result_t e;
		if (result_q.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected transfer: status %0d", got.status);
			return;
		end
		e = result_q.pop_front();
		if (got !== e) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch: exp st %0d rd %0d pr %0d/%0d c %0d s %0d",
					e.status, e.read_value, e.pair_low, e.pair_high, e.cosine, e.sine,
					" | got st %0d rd %0d pr %0d/%0d c %0d s %0d",
					got.status, got.read_value, got.pair_low, got.pair_high,
					got.cosine, got.sine);
		end
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_count = 0;
			tol_q     = 31'd1;
			rot_limit = 16'd1024;
			dim_reg   = 4'd8;
			result_q.delete();
		end else begin
			if (rsp.valid && rsp.ready)
				compare({rsp.status, rsp.read_value, rsp.pair_low, rsp.pair_high,
					rsp.cosine, rsp.sine});
			if (req.valid && req.ready)
				predict(req.opcode, req.row, req.col, req.value);
			if (cfg_we) begin
				case (cfg_index)
					jere_pkg::CFG_TOL:   tol_q     = cfg_data;
					jere_pkg::CFG_LIMIT: rot_limit = cfg_data[15:0];
					jere_pkg::CFG_SIZE:  dim_reg   = cfg_data[3:0];
					default: ;
				endcase
			end
		end
		pending = result_q.size();
	end

endmodule

// ===== sim/jacobi_eigen_rotation_engine_core_tb.sv =====
module jacobi_eigen_rotation_engine_core_tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [30:0] cfg_data;
	int          fail_count;
	int          pending;
	int          idle_pct;
	int          stall_pct;
	int          sent;

	jere_in_if  req();
	jere_out_if rsp();

	jacobi_eigen_rotation_engine_core #(.MAX_N(8), .FRAC_BITS(16)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req.sink),
		.rsp      (rsp.source)
	);

	jere_rotation_checker i_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send(logic [1:0] op, logic [2:0] r, logic [2:0] c, logic [31:0] v);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid  <= 1'b1;
		req.opcode <= op;
		req.row    <= r;
		req.col    <= c;
		req.value  <= v;
		@(negedge clk);
		while (!req.ready) @(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	task automatic settle();
		req.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_regs(logic [30:0] tol, logic [15:0] lim, logic [3:0] sz);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= jere_pkg::CFG_TOL;
		cfg_data  <= tol;
		@(posedge clk);
		cfg_index <= jere_pkg::CFG_LIMIT;
		cfg_data  <= {15'd0, lim};
		@(posedge clk);
		cfg_index <= jere_pkg::CFG_SIZE;
		cfg_data  <= {27'd0, sz};
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [31:0] rand_elem(int bits);
		logic [31:0] v;
		if (bits >= 32) return $urandom;
		v = $urandom & ((32'd1 << bits) - 1);
		return $urandom_range(1) ? -v : v;
	endfunction

	task automatic write_el(int r, int c, logic [31:0] v);
		if ($urandom_range(1)) send(jere_pkg::OP_WRITE, 3'(c), 3'(r), v);
		else send(jere_pkg::OP_WRITE, 3'(r), 3'(c), v);
	endtask

	task automatic load_matrix(int bits);
		for (int j = 0; j < 8; j++)
			for (int i = j; i < 8; i++)
				write_el(i, j, rand_elem(bits));
	endtask

	task automatic random_block();
		logic [30:0] tol;
		logic [15:0] lim;
		logic [3:0]  sz;
		int          sel, cnt, bits;
		sel = $urandom_range(9);
		tol = (sel < 5) ? 31'd1 : (sel < 8) ? 31'($urandom_range(64, 1)) :
			(sel == 8) ? 31'($urandom_range(32'h7FFFFFFF, 1)) : 31'h7FFFFFFF;
		sel = $urandom_range(9);
		lim = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : 16'($urandom_range(60, 5));
		sz  = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 2));
		program_regs(tol, lim, sz);
		sel  = $urandom_range(9);
		bits = (sel == 0) ? 32 : (sel == 1) ? 30 : $urandom_range(22, 8);
		load_matrix(bits);
		cnt = $urandom_range(40, 10);
		repeat (cnt) begin
			sel = $urandom_range(99);
			if (sel < 62)
				send(jere_pkg::OP_ITER, 3'($urandom), 3'($urandom), $urandom);
			else if (sel < 82)
				send(jere_pkg::OP_READ, 3'($urandom), 3'($urandom), $urandom);
			else if (sel < 94)
				send(jere_pkg::OP_WRITE, 3'($urandom), 3'($urandom), rand_elem(bits));
			else
				send(jere_pkg::OP_NOP, 3'($urandom), 3'($urandom), $urandom);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = jere_pkg::CFG_TOL;
		cfg_data   = '0;
		req.valid  = 1'b0;
		req.opcode = jere_pkg::OP_WRITE;
		req.row    = '0;
		req.col    = '0;
		req.value  = '0;
		rsp.ready  = 1'b0;
		idle_pct   = 0;
		stall_pct  = 0;
		sent       = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_regs(31'd1, 16'd1024, 4'd8);
		load_matrix(18);
		write_el(0, 0, 32'h7FFFFFFF);
		write_el(7, 7, 32'h80000000);
		write_el(7, 0, 32'hFFFFFFFF);
		send(jere_pkg::OP_READ, 3'd0, 3'd0, '0);
		send(jere_pkg::OP_READ, 3'd7, 3'd7, '0);
		send(jere_pkg::OP_READ, 3'd0, 3'd7, '0);
		send(jere_pkg::OP_NOP, 3'd5, 3'd2, $urandom);
		repeat (4) send(jere_pkg::OP_ITER, '0, '0, '0);
		program_regs(31'd1, 16'd0, 4'd8);
		send(jere_pkg::OP_ITER, '0, '0, '0);
		program_regs(31'h7FFFFFFF, 16'd1024, 4'd8);
		send(jere_pkg::OP_ITER, '0, '0, '0);
		program_regs(31'd1, 16'hFFFF, 4'd2);
		// equal diagonal: rotation with zero difference
		write_el(0, 0, 32'h00030000);
		write_el(1, 1, 32'h00030000);
		write_el(1, 0, 32'h00010000);
		send(jere_pkg::OP_ITER, '0, '0, '0);
		send(jere_pkg::OP_ITER, '0, '0, '0);
		send(jere_pkg::OP_READ, 3'd1, 3'd1, '0);
		program_regs(31'd1, 16'd1024, 4'd0);
		write_el(1, 0, 32'hFFFF0000);
		send(jere_pkg::OP_ITER, '0, '0, '0);
		program_regs(31'd1, 16'd1024, 4'd1);
		send(jere_pkg::OP_ITER, '0, '0, '0);
		program_regs(31'd1, 16'd1024, 4'd15);
		send(jere_pkg::OP_ITER, '0, '0, '0);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 37 : 66) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 37 : 66) : 0;
			while (sent < 100 + (ph + 1) * 330) random_block();
		end
		idle_pct = 0;

		settle();
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/jere_pkg.sv
src/jere_in_if.sv
src/jere_out_if.sv
src/jere_itu.sv
src/jacobi_eigen_rotation_engine_core.sv
sim/jere_rotation_checker.sv
sim/jacobi_eigen_rotation_engine_core_tb.sv
